// ===== src/spic_pkg.sv =====
// Package for the segment pair intersection classifier.
// Holds coordinate widths, position codes and the item structs.
// No dependencies.
package spic_pkg;

   // Grid coordinate width and the widths of derived arithmetic
   localparam int COORD_BITS = 24;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int PROD_BITS  = 2 * DIFF_BITS;
   localparam int CROSS_BITS = PROD_BITS + 1;

   // Position of a meeting on a segment
   typedef enum logic [2:0] {
      POS_OUTSIDE  = 3'd0,
      POS_INSIDE   = 3'd1,
      POS_V0       = 3'd2,
      POS_V1       = 3'd3,
      POS_PARALLEL = 3'd4
   } pos_type;

   // Sign of an orientation test
   typedef enum logic [1:0] {
      SGN_ZERO = 2'd0,
      SGN_POS  = 2'd1,
      SGN_NEG  = 2'd2
   } sgn_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
   } point_type;

   // One input item: two segments
   typedef struct packed {
      logic signed [COORD_BITS-1:0] a_start_x;
      logic signed [COORD_BITS-1:0] a_start_y;
      logic signed [COORD_BITS-1:0] a_end_x;
      logic signed [COORD_BITS-1:0] a_end_y;
      logic signed [COORD_BITS-1:0] b_start_x;
      logic signed [COORD_BITS-1:0] b_start_y;
      logic signed [COORD_BITS-1:0] b_end_x;
      logic signed [COORD_BITS-1:0] b_end_y;
   } req_type;

   // One result item
   typedef struct packed {
      pos_type where_on_a;
      pos_type where_on_b;
      logic    overlap_valid;
      pos_type overlap_on_a;
      pos_type overlap_on_b;
   } rsp_type;

endpackage

// ===== src/segment_pair_intersection_classify.sv =====
// Top level of the segment pair intersection classifier.
// Input register, spic_core, result register. Depends on spic_pkg, spic_core.
//
//   Channel | Ports                            | Direction | Payload
//   req     | req_valid, req_ready, req_data   | in        | spic_pkg::req_type
//   rsp     | rsp_valid, rsp_ready, rsp_data   | out       | spic_pkg::rsp_type
//
// One item per cycle sustained while rsp_ready stays high; an accepted item passes
// through the input register, then spic_core, then the result register.
// Reset is synchronous and active high; it empties both registers.
// A stalled result holds in the result register while one more item is
// taken into the input register; req_ready then drops until rsp_ready.
module segment_pair_intersection_classify (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  spic_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output spic_pkg::rsp_type rsp_data
);

   logic              in_valid_ff, in_valid_in;
   spic_pkg::req_type in_data_ff;
   logic              out_valid_ff, out_valid_in;
   spic_pkg::rsp_type out_data_ff;
   spic_pkg::rsp_type core_rsp;
   logic              out_adv;
   logic              in_adv;

   // Advance the result register when it is empty or being taken
   assign out_adv   = !out_valid_ff || rsp_ready;
   // Advance the input register when it is empty or moving forward
   assign in_adv    = !in_valid_ff || out_adv;
   assign req_ready = in_adv;

   assign in_valid_in  = in_adv ? req_valid : in_valid_ff;
   assign out_valid_in = out_adv ? in_valid_ff : out_valid_ff;

   spic_core u_core (
      .req (in_data_ff),
      .rsp (core_rsp)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers: load on advance, hold otherwise
   always_ff @(posedge clock) begin
      if (in_adv) begin
         in_data_ff <= req_data;
      end
      if (out_adv) begin
         out_data_ff <= core_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

`ifndef NO_ASSERTIONS
   // An item moving out of the input register lands in the result register
   a_item_moves: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_adv |=> out_valid_ff)
      else $error("item lost between input and result registers");

   // Parallel is reported on both segments or on neither
   a_parallel_pair: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> ((out_data_ff.where_on_a == spic_pkg::POS_PARALLEL) ==
                        (out_data_ff.where_on_b == spic_pkg::POS_PARALLEL)))
      else $error("parallel reported on one segment only");

   // Refinement flag follows the parallel report
   a_overlap_flag: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_data_ff.overlap_valid ==
                        (out_data_ff.where_on_a == spic_pkg::POS_PARALLEL)))
      else $error("overlap_valid disagrees with where_on_a");

   // Refinement fields stay clear when not collinear
   a_overlap_clear: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_data_ff.overlap_valid |->
         out_data_ff.overlap_on_a == spic_pkg::POS_OUTSIDE &&
         out_data_ff.overlap_on_b == spic_pkg::POS_OUTSIDE)
      else $error("refinement set on a non-collinear pair");
`endif

endmodule

// ===== src/spic_core.sv =====
// Combinational classifier: orientation signs, meeting positions and
// collinear refinement for one segment pair. Depends on spic_pkg.
module spic_core (
   input  spic_pkg::req_type req,
   output spic_pkg::rsp_type rsp
);

   // Sign of the cross product (q - p) x (r - p)
   function automatic spic_pkg::sgn_type orient(
      spic_pkg::point_type p, spic_pkg::point_type q, spic_pkg::point_type r);
      logic signed [spic_pkg::DIFF_BITS-1:0]  ux, uy, vx, vy;
      logic signed [spic_pkg::PROD_BITS-1:0]  m0, m1;
      logic signed [spic_pkg::CROSS_BITS-1:0] cr;
      spic_pkg::sgn_type                      s;
      ux = {q.x[spic_pkg::COORD_BITS-1], q.x} - {p.x[spic_pkg::COORD_BITS-1], p.x};
      uy = {q.y[spic_pkg::COORD_BITS-1], q.y} - {p.y[spic_pkg::COORD_BITS-1], p.y};
      vx = {r.x[spic_pkg::COORD_BITS-1], r.x} - {p.x[spic_pkg::COORD_BITS-1], p.x};
      vy = {r.y[spic_pkg::COORD_BITS-1], r.y} - {p.y[spic_pkg::COORD_BITS-1], p.y};
      m0 = ux * vy;
      m1 = uy * vx;
      cr = spic_pkg::CROSS_BITS'(m0) - spic_pkg::CROSS_BITS'(m1);
      if (cr == '0) begin
         s = spic_pkg::SGN_ZERO;
      end else if (cr[spic_pkg::CROSS_BITS-1]) begin
         s = spic_pkg::SGN_NEG;
      end else begin
         s = spic_pkg::SGN_POS;
      end
      return s;
   endfunction

   // Position of point p on segment s0-s1, given the sign of p against it.
   // On the line, strictly inside means strictly between the endpoints along
   // an axis on which the endpoints differ.
   function automatic spic_pkg::pos_type pt_on_seg(
      spic_pkg::point_type p, spic_pkg::point_type s0, spic_pkg::point_type s1,
      spic_pkg::sgn_type o);
      logic              between;
      spic_pkg::pos_type pos;
      if (s0.x != s1.x) begin
         between = (s0.x < p.x && p.x < s1.x) || (s1.x < p.x && p.x < s0.x);
      end else begin
         between = (s0.y < p.y && p.y < s1.y) || (s1.y < p.y && p.y < s0.y);
      end
      if (o != spic_pkg::SGN_ZERO) begin
         pos = spic_pkg::POS_OUTSIDE;
      end else if (p == s0) begin
         pos = spic_pkg::POS_V0;
      end else if (p == s1) begin
         pos = spic_pkg::POS_V1;
      end else if (between) begin
         pos = spic_pkg::POS_INSIDE;
      end else begin
         pos = spic_pkg::POS_OUTSIDE;
      end
      return pos;
   endfunction

   spic_pkg::point_type a0, a1, b0, b1;
   spic_pkg::sgn_type   sa0, sa1, sb0, sb1;
   spic_pkg::pos_type   pa0, pa1, pb0, pb1;
   spic_pkg::pos_type   wa, wb, oa, ob;
   logic                any_inside;

   // Unpack endpoints
   assign a0 = '{x: req.a_start_x, y: req.a_start_y};
   assign a1 = '{x: req.a_end_x,   y: req.a_end_y};
   assign b0 = '{x: req.b_start_x, y: req.b_start_y};
   assign b1 = '{x: req.b_end_x,   y: req.b_end_y};

   // Four orientation signs, each endpoint against the other segment
   assign sa0 = orient(b0, b1, a0);
   assign sa1 = orient(b0, b1, a1);
   assign sb0 = orient(a0, a1, b0);
   assign sb1 = orient(a0, a1, b1);

   // Endpoint positions on the other segment
   assign pa0 = pt_on_seg(a0, b0, b1, sa0);
   assign pa1 = pt_on_seg(a1, b0, b1, sa1);
   assign pb0 = pt_on_seg(b0, a0, a1, sb0);
   assign pb1 = pt_on_seg(b1, a0, a1, sb1);

   assign any_inside = (pa0 == spic_pkg::POS_INSIDE) || (pa1 == spic_pkg::POS_INSIDE) ||
                       (pb0 == spic_pkg::POS_INSIDE) || (pb1 == spic_pkg::POS_INSIDE);

   // Classify the meeting on each segment
   always_comb begin
      if (sa0 == sa1 || sb0 == sb1) begin
         if (sa0 == spic_pkg::SGN_ZERO && sb0 == spic_pkg::SGN_ZERO) begin
            wa = spic_pkg::POS_PARALLEL;
            wb = spic_pkg::POS_PARALLEL;
         end else begin
            wa = spic_pkg::POS_OUTSIDE;
            wb = spic_pkg::POS_OUTSIDE;
         end
      end else begin
         if (sb0 == spic_pkg::SGN_ZERO) begin
            wb = spic_pkg::POS_V0;
         end else if (sb1 == spic_pkg::SGN_ZERO) begin
            wb = spic_pkg::POS_V1;
         end else begin
            wb = spic_pkg::POS_INSIDE;
         end
         if (sa0 == spic_pkg::SGN_ZERO) begin
            wa = spic_pkg::POS_V0;
         end else if (sa1 == spic_pkg::SGN_ZERO) begin
            wa = spic_pkg::POS_V1;
         end else begin
            wa = spic_pkg::POS_INSIDE;
         end
      end
   end

   // Collinear refinement from endpoint positions
   always_comb begin
      oa = spic_pkg::POS_OUTSIDE;
      ob = spic_pkg::POS_OUTSIDE;
      if (any_inside) begin
         oa = spic_pkg::POS_PARALLEL;
         ob = spic_pkg::POS_PARALLEL;
      end else if (pa0 == spic_pkg::POS_V0) begin
         if (pa1 == spic_pkg::POS_OUTSIDE || pa1 == spic_pkg::POS_V0) begin
            oa = spic_pkg::POS_V0;
            ob = spic_pkg::POS_V0;
         end else begin
            oa = spic_pkg::POS_PARALLEL;
            ob = spic_pkg::POS_PARALLEL;
         end
      end else if (pa0 == spic_pkg::POS_V1) begin
         if (pa1 == spic_pkg::POS_OUTSIDE || pa1 == spic_pkg::POS_V1) begin
            oa = spic_pkg::POS_V0;
            ob = spic_pkg::POS_V1;
         end else begin
            oa = spic_pkg::POS_PARALLEL;
            ob = spic_pkg::POS_PARALLEL;
         end
      end else if (pb0 == spic_pkg::POS_V0) begin
         if (pb1 == spic_pkg::POS_OUTSIDE || pb1 == spic_pkg::POS_V0) begin
            oa = spic_pkg::POS_V0;
            ob = spic_pkg::POS_V0;
         end else begin
            oa = spic_pkg::POS_PARALLEL;
            ob = spic_pkg::POS_PARALLEL;
         end
      end else if (pb0 == spic_pkg::POS_V1) begin
         if (pb1 == spic_pkg::POS_OUTSIDE || pb1 == spic_pkg::POS_V1) begin
            oa = spic_pkg::POS_V1;
            ob = spic_pkg::POS_V0;
         end else begin
            oa = spic_pkg::POS_PARALLEL;
            ob = spic_pkg::POS_PARALLEL;
         end
      end
   end

   // Assemble the result; refinement applies only to collinear pairs
   always_comb begin
      rsp.where_on_a    = wa;
      rsp.where_on_b    = wb;
      rsp.overlap_valid = (wa == spic_pkg::POS_PARALLEL) && (wb == spic_pkg::POS_PARALLEL);
      rsp.overlap_on_a  = rsp.overlap_valid ? oa : spic_pkg::POS_OUTSIDE;
      rsp.overlap_on_b  = rsp.overlap_valid ? ob : spic_pkg::POS_OUTSIDE;
   end

endmodule
